// ===== rtl/isa_pkg.sv =====
`timescale 1ns / 1ps

package isa_pkg;

    localparam int POS_W = 6;

    localparam logic [2:0] OP_PUSH   = 3'd0;
    localparam logic [2:0] OP_INSERT = 3'd1;
    localparam logic [2:0] OP_POP    = 3'd2;
    localparam logic [2:0] OP_REMOVE = 3'd3;
    localparam logic [2:0] OP_GET    = 3'd4;
    localparam logic [2:0] OP_SET    = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [POS_W-1:0]   position;
        logic signed [31:0] word_in;
    } t_request;

    typedef struct packed {
        logic signed [31:0] word_out;
        logic [1:0]         status;
        logic [6:0]         entry_count;
        logic               is_empty;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_READ,
        S_INS_RD,
        S_INS_WR,
        S_REM_RD,
        S_REM_WR
    } t_state;

    typedef enum logic [1:0] {
        RD_AT_POS,
        RD_AT_LAST,
        RD_BELOW_IDX,
        RD_ABOVE_IDX
    } t_rd_sel;

    typedef enum logic [1:0] {
        WR_AT_COUNT,
        WR_AT_POS,
        WR_AT_IDX
    } t_wr_sel;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_COUNT,
        IDX_POS,
        IDX_DEC,
        IDX_INC
    } t_idx_op;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } t_cnt_op;

    typedef struct packed {
        logic    load;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    wr_en;
        t_wr_sel wr_sel;
        t_idx_op idx_op;
        t_cnt_op cnt_op;
        logic    finish;
        logic    use_rd;
    } t_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       fault;
        logic       sweep_done;
    } t_stat;

endpackage

// ===== rtl/isa_ctrl.sv =====
`timescale 1ns / 1ps

module isa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  isa_pkg::t_stat i_stat,
    output logic          o_busy,
    output isa_pkg::t_cmd o_cmd
);
    import isa_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.rd_en  = 1'b0;
        o_cmd.rd_sel = RD_AT_POS;
        o_cmd.wr_en  = 1'b0;
        o_cmd.wr_sel = WR_AT_COUNT;
        o_cmd.idx_op = IDX_HOLD;
        o_cmd.cnt_op = CNT_HOLD;
        o_cmd.finish = 1'b0;
        o_cmd.use_rd = 1'b0;
        o_busy       = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.fault) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    case (i_stat.op)
                        OP_PUSH: begin
                            o_cmd.wr_en  = 1'b1;
                            o_cmd.wr_sel = WR_AT_COUNT;
                            o_cmd.cnt_op = CNT_INC;
                            o_cmd.finish = 1'b1;
                            n_state      = S_IDLE;
                        end
                        OP_SET: begin
                            o_cmd.wr_en  = 1'b1;
                            o_cmd.wr_sel = WR_AT_POS;
                            o_cmd.finish = 1'b1;
                            n_state      = S_IDLE;
                        end
                        OP_GET: begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = RD_AT_POS;
                            n_state      = S_READ;
                        end
                        OP_POP: begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = RD_AT_LAST;
                            n_state      = S_READ;
                        end
                        OP_INSERT: begin
                            o_cmd.idx_op = IDX_COUNT;
                            n_state      = S_INS_RD;
                        end
                        OP_REMOVE: begin
                            o_cmd.idx_op = IDX_POS;
                            n_state      = S_REM_RD;
                        end
                        default: begin
                            o_cmd.finish = 1'b1;
                            n_state      = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ: begin
                o_cmd.finish = 1'b1;
                o_cmd.use_rd = 1'b1;
                o_cmd.cnt_op = (i_stat.op == OP_POP) ? CNT_DEC : CNT_HOLD;
                n_state      = S_IDLE;
            end
            // Insert walks down from the back, moving one entry up per pass.
            S_INS_RD: begin
                if (i_stat.sweep_done) begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_sel = WR_AT_POS;
                    o_cmd.cnt_op = CNT_INC;
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_BELOW_IDX;
                    n_state      = S_INS_WR;
                end
            end
            S_INS_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_AT_IDX;
                o_cmd.idx_op = IDX_DEC;
                n_state      = S_INS_RD;
            end
            // Remove walks up from the removed slot, moving one entry down per pass.
            S_REM_RD: begin
                if (i_stat.sweep_done) begin
                    o_cmd.cnt_op = CNT_DEC;
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_ABOVE_IDX;
                    n_state      = S_REM_WR;
                end
            end
            S_REM_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_AT_IDX;
                o_cmd.idx_op = IDX_INC;
                n_state      = S_REM_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/isa_dp.sv =====
`timescale 1ns / 1ps

module isa_dp #(
    parameter int CAPACITY   = 64,
    parameter int WORD_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  isa_pkg::t_request i_req,
    input  isa_pkg::t_cmd     i_cmd,
    output isa_pkg::t_stat    o_stat,
    output logic              o_done,
    output isa_pkg::t_result  o_result
);
    import isa_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    logic [WORD_WIDTH-1:0] r_mem [CAPACITY];
    logic [WORD_WIDTH-1:0] r_rd_data;
    logic [WORD_WIDTH-1:0] r_word;
    logic [2:0]            r_op;
    logic [POS_W-1:0]      r_pos;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic [CW-1:0]         r_idx;
    logic [CW-1:0]         n_idx;
    logic                  r_done;
    t_result               r_result;
    t_result               n_result;

    logic [PW-1:0]         pos_ext;
    logic [PW-1:0]         cnt_ext;
    logic [CW-1:0]         cnt_m1;
    logic [CW-1:0]         idx_m1;
    logic [CW-1:0]         idx_p1;
    logic                  full;
    logic [1:0]            code;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         wr_addr;
    logic [WORD_WIDTH-1:0] wr_data;
    logic [63:0]           in_wide;
    logic [63:0]           rd_wide;

    assign in_wide = 64'($signed(i_req.word_in));
    assign rd_wide = 64'($signed(r_rd_data));

    assign pos_ext = PW'(r_pos);
    assign cnt_ext = PW'(r_count);
    assign cnt_m1  = r_count - 1'b1;
    assign idx_m1  = r_idx - 1'b1;
    assign idx_p1  = r_idx + 1'b1;
    assign full    = (r_count == CAP);

    // The checks only ever see the count from before the request, because the
    // count changes in the same cycle that the result is captured.
    always_comb begin
        case (r_op)
            OP_PUSH: begin
                code = full ? ST_FULL : ST_OK;
            end
            OP_INSERT: begin
                if (pos_ext > cnt_ext) begin
                    code = ST_BAD_INDEX;
                end else begin
                    code = full ? ST_FULL : ST_OK;
                end
            end
            OP_POP: begin
                code = (r_count == '0) ? ST_EMPTY : ST_OK;
            end
            OP_REMOVE, OP_GET, OP_SET: begin
                code = (pos_ext >= cnt_ext) ? ST_BAD_INDEX : ST_OK;
            end
            default: begin
                code = ST_OK;
            end
        endcase
    end

    always_comb begin
        o_stat.op    = r_op;
        o_stat.fault = (code != ST_OK);
        if (r_op == OP_INSERT) begin
            o_stat.sweep_done = (PW'(r_idx) == pos_ext);
        end else begin
            o_stat.sweep_done = (idx_p1 == r_count);
        end
    end

    always_comb begin
        case (i_cmd.rd_sel)
            RD_AT_POS:    rd_addr = pos_ext[AW-1:0];
            RD_AT_LAST:   rd_addr = cnt_m1[AW-1:0];
            RD_BELOW_IDX: rd_addr = idx_m1[AW-1:0];
            RD_ABOVE_IDX: rd_addr = idx_p1[AW-1:0];
            default:      rd_addr = pos_ext[AW-1:0];
        endcase
    end

    always_comb begin
        case (i_cmd.wr_sel)
            WR_AT_COUNT: begin
                wr_addr = r_count[AW-1:0];
                wr_data = r_word;
            end
            WR_AT_POS: begin
                wr_addr = pos_ext[AW-1:0];
                wr_data = r_word;
            end
            WR_AT_IDX: begin
                wr_addr = r_idx[AW-1:0];
                wr_data = r_rd_data;
            end
            default: begin
                wr_addr = r_count[AW-1:0];
                wr_data = r_word;
            end
        endcase
    end

    always_comb begin
        case (i_cmd.cnt_op)
            CNT_INC: n_count = r_count + 1'b1;
            CNT_DEC: n_count = cnt_m1;
            default: n_count = r_count;
        endcase
    end

    always_comb begin
        case (i_cmd.idx_op)
            IDX_COUNT: n_idx = r_count;
            IDX_POS:   n_idx = pos_ext[CW-1:0];
            IDX_DEC:   n_idx = idx_m1;
            IDX_INC:   n_idx = idx_p1;
            default:   n_idx = r_idx;
        endcase
    end

    always_comb begin
        n_result.word_out    = i_cmd.use_rd ? rd_wide[31:0] : '0;
        n_result.status      = code;
        n_result.entry_count = 7'(n_count);
        n_result.is_empty    = (n_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_req.opcode;
            r_pos  <= i_req.position;
            r_word <= in_wide[WORD_WIDTH-1:0];
        end
        r_idx <= n_idx;
        if (i_cmd.finish) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= i_cmd.finish;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP)
        else $error("entry count exceeds capacity");

    a_error_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_result.status != ST_OK) |-> (r_count == $past(r_count)))
        else $error("failed request changed the entry count");

    a_count_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_result.entry_count == 7'(r_count)))
        else $error("reported count differs from stored count");

endmodule

// ===== rtl/indexed_shift_array_top.sv =====
`timescale 1ns / 1ps
// Ordered array of signed words with fixed capacity, driven one request at a time.
// Request channel: a request transfers on a rising edge where start is high and
// busy is low; it carries opcode, position and word_in in i_req.
// Result channel: o_done is high for exactly one cycle with o_result valid; the
// receiver cannot stall, so each result is taken in that cycle.
// Steps after the request transfer: push, set, errors and unused opcodes finish in
// the decode state; get and pop add a read state; insert and remove add a read
// and a write state per moved entry and then a final state that finishes.
// The shifts run through a memory with one read and one write port; each moved
// entry takes a read state and a write state. busy is low again in the cycle
// o_done is high, so the next request can transfer at the same edge as the result.
// One request is in flight at a time.
// Reset empties the array (count zero) and clears o_done; stored words are not
// cleared, since no entry is read before it has been written.
module indexed_shift_array_top #(
    parameter int CAPACITY   = 64,
    parameter int WORD_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  isa_pkg::t_request i_req,
    output logic              o_done,
    output isa_pkg::t_result  o_result
);
    import isa_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    isa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    isa_dp #(
        .CAPACITY   (CAPACITY),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_done   (o_done),
        .o_result (o_result)
    );

    a_transfer_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after a request transfer");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while still busy");

endmodule

// ===== tb/indexed_shift_array_top_test.sv =====
`timescale 1ns / 1ps

module indexed_shift_array_top_test;
    import isa_pkg::*;

    localparam int CAP = 64;
    // Opcodes 6 and 7 have no function; the block must leave the array alone.
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    logic     i_clk;
    logic     i_rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    t_request i_req = '0;
    logic     o_done;
    t_result  o_result;

    logic signed [31:0] array_words [CAP];
    int unsigned        array_count;
    t_result            pending_results [$];
    int                 fault_count;
    bit                 idle_enabled;
    bit                 growing;

    indexed_shift_array_top #(
        .CAPACITY(CAP),
        .WORD_WIDTH(32)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_req(i_req),
        .o_done(o_done),
        .o_result(o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic t_request make_req(logic [2:0] op, int unsigned pos,
                                          logic [31:0] word);
        t_request req;
        req.opcode   = op;
        req.position = pos[POS_W-1:0];
        req.word_in  = word;
        return req;
    endfunction

    // Applies one request to the local copy of the array and returns what
    // the block should report for it.
    function automatic t_result apply_array_op(t_request req);
        t_result     res;
        int unsigned pos;
        pos = req.position;
        res.word_out = '0;
        res.status   = ST_OK;
        case (req.opcode)
            OP_PUSH: begin
                if (array_count >= CAP) begin
                    res.status = ST_FULL;
                end else begin
                    array_words[array_count] = req.word_in;
                    array_count++;
                end
            end
            OP_INSERT: begin
                if (pos > array_count) begin
                    res.status = ST_BAD_INDEX;
                end else if (array_count >= CAP) begin
                    res.status = ST_FULL;
                end else begin
                    for (int i = array_count; i > pos; i--)
                        array_words[i] = array_words[i-1];
                    array_words[pos] = req.word_in;
                    array_count++;
                end
            end
            OP_POP: begin
                if (array_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    array_count--;
                    res.word_out = array_words[array_count];
                end
            end
            OP_REMOVE: begin
                if (pos >= array_count) begin
                    res.status = ST_BAD_INDEX;
                end else begin
                    for (int i = pos; i + 1 < array_count; i++)
                        array_words[i] = array_words[i+1];
                    array_count--;
                end
            end
            OP_GET: begin
                if (pos >= array_count)
                    res.status = ST_BAD_INDEX;
                else
                    res.word_out = array_words[pos];
            end
            OP_SET: begin
                if (pos >= array_count)
                    res.status = ST_BAD_INDEX;
                else
                    array_words[pos] = req.word_in;
            end
            default: ;
        endcase
        res.entry_count = array_count[6:0];
        res.is_empty    = (array_count == 0);
        return res;
    endfunction

    // Called at a rising edge. Holds the request until the block takes it,
    // leaving start high so a following request can go out without a gap.
    task automatic issue(input t_request req);
        if (idle_enabled && $urandom_range(0, 2) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= req;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_results.push_back(apply_array_op(req));
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_done === 1'b1) begin
            if (pending_results.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("%0t: result with no request outstanding: word %0d status %0d",
                             $realtime, o_result.word_out, o_result.status);
            end else begin
                want = pending_results.pop_front();
                if (o_result.word_out !== want.word_out || o_result.status !== want.status ||
                    o_result.entry_count !== want.entry_count ||
                    o_result.is_empty !== want.is_empty) begin
                    fault_count++;
                    if (fault_count <= 10) begin
                        $display("%0t: mismatch (expected/actual): word %0d/%0d status %0d/%0d",
                                 $realtime, want.word_out, o_result.word_out,
                                 want.status, o_result.status);
                        $display("    count %0d/%0d empty %0d/%0d",
                                 want.entry_count, o_result.entry_count,
                                 want.is_empty, o_result.is_empty);
                    end
                end
            end
        end
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    // Mostly well-formed requests with in-range positions; the array is
    // steered between filling and draining so every count gets visited.
    function automatic t_request pick_request();
        int unsigned r;
        int unsigned pos;
        logic [2:0]  op;
        if (array_count == CAP)
            growing = 1'b0;
        else if (array_count == 0)
            growing = 1'b1;
        else if ($urandom_range(0, 40) == 0)
            growing = ~growing;
        r = $urandom_range(0, 99);
        if (r < 3)
            op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
        else if (r < (growing ? 28 : 11))
            op = OP_PUSH;
        else if (r < (growing ? 53 : 19))
            op = OP_INSERT;
        else if (r < (growing ? 61 : 44))
            op = OP_POP;
        else if (r < 69)
            op = OP_REMOVE;
        else if (r < 84)
            op = OP_GET;
        else
            op = OP_SET;
        if ($urandom_range(0, 99) < 15)
            pos = $urandom_range(0, 63);
        else if (op == OP_INSERT)
            pos = $urandom_range(0, (array_count < CAP) ? array_count : CAP - 1);
        else
            pos = (array_count == 0) ? 0 : $urandom_range(0, array_count - 1);
        return make_req(op, pos, pick_word());
    endfunction

    task automatic test_directed();
        issue(make_req(OP_POP, 0, 32'h1234_5678));
        issue(make_req(OP_GET, 0, '0));
        issue(make_req(OP_REMOVE, 0, '0));
        issue(make_req(OP_SET, 0, 32'h5555_5555));
        issue(make_req(OP_INSERT, 1, 32'haaaa_aaaa));
        issue(make_req(OP_SPARE_A, 63, 32'hffff_ffff));
        issue(make_req(OP_SPARE_B, 21, 32'h8000_0001));
        issue(make_req(OP_INSERT, 0, 32'h7fff_ffff));
        issue(make_req(OP_PUSH, 42, 32'h8000_0000));
        issue(make_req(OP_PUSH, 0, 32'h0000_0000));
        issue(make_req(OP_PUSH, 0, 32'hffff_ffff));
        issue(make_req(OP_INSERT, 4, 32'h1234_5678));
        issue(make_req(OP_INSERT, 2, -32'sd5));
        issue(make_req(OP_GET, 0, '0));
        issue(make_req(OP_GET, 5, '0));
        issue(make_req(OP_GET, 6, '0));
        issue(make_req(OP_SET, 6, 32'h0f0f_0f0f));
        issue(make_req(OP_SET, 5, 32'hf0f0_f0f0));
        issue(make_req(OP_SET, 0, 32'h8000_0000));
        issue(make_req(OP_REMOVE, 5, '0));
        issue(make_req(OP_REMOVE, 0, '0));
        issue(make_req(OP_REMOVE, 6, '0));
        issue(make_req(OP_POP, 0, '0));
        issue(make_req(OP_GET, 63, '0));
    endtask

    // Fill to capacity, hit the full cases and the longest shifts, then drain.
    task automatic test_full_array();
        while (array_count < CAP) begin
            if ($urandom_range(0, 1))
                issue(make_req(OP_PUSH, $urandom_range(0, 63), pick_word()));
            else
                issue(make_req(OP_INSERT, $urandom_range(0, array_count), pick_word()));
        end
        issue(make_req(OP_PUSH, 0, pick_word()));
        issue(make_req(OP_INSERT, 0, pick_word()));
        issue(make_req(OP_INSERT, 63, pick_word()));
        issue(make_req(OP_GET, 63, '0));
        issue(make_req(OP_SET, 63, pick_word()));
        issue(make_req(OP_REMOVE, 0, '0));
        issue(make_req(OP_INSERT, 0, pick_word()));
        issue(make_req(OP_REMOVE, 63, '0));
        issue(make_req(OP_INSERT, 63, pick_word()));
        while (array_count > 0)
            issue(make_req(OP_POP, $urandom_range(0, 63), '0));
        issue(make_req(OP_POP, 0, '0));
    endtask

    task automatic test_random_mixed(input int n_items);
        for (int n = 0; n < n_items; n++) begin
            if (n % 64 == 0)
                idle_enabled = $urandom_range(0, 1);
            issue(pick_request());
        end
    endtask

    task automatic test_random_back_to_back(input int n_items);
        idle_enabled = 1'b0;
        for (int n = 0; n < n_items; n++)
            issue(pick_request());
    endtask

    initial begin
        fault_count  = 0;
        array_count  = 0;
        growing      = 1'b1;
        idle_enabled = 1'b1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_array();
        test_random_mixed(850);
        test_random_back_to_back(300);

        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fault_count == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
